### rtl/ica_pkg.sv
// Shared types, constants and helper functions of the IMU complementary attitude filter.
// Used by every module in rtl; depends on nothing else.
`timescale 1ns / 1ps
package ica_pkg;

  localparam int unsigned AngleFracBits = 24;
  localparam int unsigned AngW = 36;
  localparam int unsigned DivSteps = 30;

  // Configuration register indexes.
  localparam logic [2:0] CfgGyroXOffset = 3'd0;
  localparam logic [2:0] CfgGyroYOffset = 3'd1;
  localparam logic [2:0] CfgGyroZOffset = 3'd2;
  localparam logic [2:0] CfgPitchTrim   = 3'd3;
  localparam logic [2:0] CfgRollTrim    = 3'd4;

  localparam logic signed [31:0] PitchTrimReset = 32'sd35232154;
  localparam logic signed [31:0] RollTrimReset  = 32'sd68786586;

  localparam logic signed [31:0] RateK  = 32'sd67180160;
  localparam logic signed [31:0] YawK   = 32'sd1172079;
  localparam logic signed [31:0] DegK   = 32'sd60079210;
  localparam logic signed [31:0] BlendK = 32'sd429497;
  localparam logic signed [31:0] LpK    = 32'sd107374182;
  localparam logic signed [31:0] Div20K = 32'sd13421773;
  localparam logic signed [31:0] Div6K  = 32'sd44739243;
  localparam logic signed [33:0] HalfPi = 34'sd1686629713;
  localparam logic signed [29:0] Q28One = 30'sd268435456;
  localparam logic [30:0]        Q30One = 31'd1073741824;

  localparam logic [61:0] MagTopBit  = 62'd1 << 30;
  localparam logic [61:0] AsinTopBit = 62'd1 << 60;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] dz;
    logic signed [31:0] pitch_trim;
    logic signed [31:0] roll_trim;
    logic               acc_zero;
  } ica_item_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_INC_P, ST_INC_R, ST_YAW, ST_X, ST_XX, ST_X2, ST_D20, ST_U, ST_XU,
    ST_V, ST_D6, ST_V6, ST_XS, ST_S, ST_PS, ST_PSU, ST_RS, ST_RSU, ST_SQY, ST_SQZ,
    ST_SQS, ST_MAG, ST_MAGW, ST_ANG, ST_DIV, ST_ROOT, ST_ROOTW, ST_PM, ST_PA, ST_SP,
    ST_R, ST_DEG, ST_DEGU, ST_TRIM, ST_BLEND, ST_BP, ST_BR, ST_LP, ST_LPP, ST_LPR,
    ST_OUT
  } ica_state_e;

  // Round to nearest, ties away from zero, after an arithmetic right shift.
  function automatic logic signed [69:0] rnd_shift(input logic signed [69:0] v,
                                                   input int unsigned s);
    logic [69:0] m;
    m = v[69] ? 70'(-v) : 70'(v);
    m = (m + (70'd1 << (s - 1))) >> s;
    return v[69] ? $signed(70'(-m)) : $signed(m);
  endfunction

  function automatic logic signed [35:0] sat36(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd34359738367;
    lo = -40'sd34359738368;
    if (v > hi) return 36'(hi);
    if (v < lo) return 36'(lo);
    return 36'(v);
  endfunction

  // Abramowitz-Stegun 4.4.46 coefficients, Q30.
  function automatic logic signed [31:0] asin_coef(input logic [2:0] i);
    logic signed [31:0] c;
    case (i)
      3'd0: c = 32'sd1686629690;
      3'd1: c = -32'sd230423709;
      3'd2: c = 32'sd95540460;
      3'd3: c = -32'sd53874249;
      3'd4: c = 32'sd33169905;
      3'd5: c = -32'sd18348235;
      3'd6: c = 32'sd7161955;
      3'd7: c = -32'sd1355589;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/ica_front.sv
// Front end: configuration registers, input handshake, offset correction and a two-entry queue.
// Depends on ica_pkg.
`timescale 1ns / 1ps
module ica_front import ica_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  output logic               q_valid_o,
  output ica_item_t          q_item_o,
  input  logic               q_pop_i
);

  logic signed [15:0] off_x_q, off_y_q, off_z_q;
  logic signed [31:0] pitch_trim_q, roll_trim_q;
  ica_item_t          mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               push;
  ica_item_t          item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q      <= '0;
      off_y_q      <= '0;
      off_z_q      <= '0;
      pitch_trim_q <= PitchTrimReset;
      roll_trim_q  <= RollTrimReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGyroXOffset: off_x_q <= cfg_data_i[15:0];
        CfgGyroYOffset: off_y_q <= cfg_data_i[15:0];
        CfgGyroZOffset: off_z_q <= cfg_data_i[15:0];
        CfgPitchTrim:   pitch_trim_q <= cfg_data_i;
        CfgRollTrim:    roll_trim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Each beat is classified here: a zero accel vector skips the angle work later.
  always_comb begin
    item.ax         = accel_x_i;
    item.ay         = accel_y_i;
    item.az         = accel_z_i;
    item.dx         = $signed({rate_x_i[15], rate_x_i}) - $signed({off_x_q[15], off_x_q});
    item.dy         = $signed({rate_y_i[15], rate_y_i}) - $signed({off_y_q[15], off_y_q});
    item.dz         = $signed({rate_z_i[15], rate_z_i}) - $signed({off_z_q[15], off_z_q});
    item.pitch_trim = pitch_trim_q;
    item.roll_trim  = roll_trim_q;
    item.acc_zero   = (accel_x_i == '0) && (accel_y_i == '0) && (accel_z_i == '0);
  end

  assign in_stall_o = cnt_q[1];
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

### rtl/ica_root.sv
// Iterative integer square root, one result bit per cycle.
// Depends on ica_pkg.
`timescale 1ns / 1ps
module ica_root import ica_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [61:0] radicand_i,
  input  logic [61:0] top_bit_i,
  output logic        done_o,
  output logic [30:0] root_o
);

  logic [61:0] n_q, n_d, res_q, res_d, bit_q, bit_d, trial;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    n_d    = n_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = res_q + bit_q;
    if (start_i) begin
      n_d    = radicand_i;
      res_d  = '0;
      bit_d  = top_bit_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_d   = n_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_d == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[30:0];

endmodule

### rtl/ica_back.sv
// Back end: sequencer around one shared multiplier, the divider loop and the filter state.
// Depends on ica_pkg and ica_root.
`timescale 1ns / 1ps
module ica_back import ica_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ica_item_t          q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [35:0] pitch_smoothed_o,
  output logic signed [35:0] roll_smoothed_o
);

  ica_state_e         state_q, state_d;
  ica_item_t          item_q, item_d;
  logic signed [35:0] pe_q, pe_d, re_q, re_d, plp_q, plp_d, rlp_q, rlp_d;
  logic signed [35:0] pa_q, pa_d, ra_q, ra_d, outp_q, outp_d, outr_q, outr_d;
  logic               seeded_q, seeded_d, outv_q, outv_d, axis_q, axis_d;
  logic signed [25:0] x_q, x_d, x2_q, x2_d, v_q, v_d;
  logic signed [29:0] u_q, u_d;
  logic signed [26:0] s_q, s_d;
  logic [31:0]        acc_q, acc_d;
  logic [15:0]        mag_q, mag_d;
  logic [30:0]        qr_q, qr_d, sq_q, sq_d;
  logic [16:0]        rem_q, rem_d;
  logic [4:0]         cnt_q, cnt_d;
  logic signed [31:0] p_q, p_d, r_q, r_d;
  logic [2:0]         pidx_q, pidx_d;
  logic signed [32:0] dang_q, dang_d;
  logic signed [69:0] prod_q;
  logic signed [37:0] mul_a;
  logic signed [31:0] mul_b;
  logic               root_start, root_done;
  logic [61:0]        root_rad, root_top;
  logic [30:0]        root_res;
  logic signed [15:0] comp;
  logic signed [16:0] comp17;
  logic [16:0]        mabs;
  logic [17:0]        rem2;
  logic signed [33:0] rtmp;
  logic signed [32:0] dtmp;
  logic signed [31:0] trim;

  ica_root u_root (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (root_start),
    .radicand_i(root_rad),
    .top_bit_i (root_top),
    .done_o    (root_done),
    .root_o    (root_res)
  );

  always_comb begin
    state_d = state_q;  item_d = item_q;
    pe_d = pe_q;  re_d = re_q;  plp_d = plp_q;  rlp_d = rlp_q;
    pa_d = pa_q;  ra_d = ra_q;  outp_d = outp_q;  outr_d = outr_q;
    seeded_d = seeded_q;  axis_d = axis_q;
    outv_d = outv_q && out_stall_i;
    x_d = x_q;  x2_d = x2_q;  v_d = v_q;  u_d = u_q;  s_d = s_q;
    acc_d = acc_q;  mag_d = mag_q;  qr_d = qr_q;  sq_d = sq_q;
    rem_d = rem_q;  cnt_d = cnt_q;  p_d = p_q;  r_d = r_q;  pidx_d = pidx_q;
    dang_d = dang_q;
    mul_a = '0;  mul_b = '0;
    q_pop_o = 1'b0;
    root_start = 1'b0;
    root_rad = 62'(acc_q);
    root_top = MagTopBit;
    comp = axis_q ? item_q.ax : item_q.ay;
    comp17 = {comp[15], comp};
    mabs = comp17[16] ? 17'(-comp17) : 17'(comp17);
    rem2 = {rem_q, 1'b0};
    rtmp = HalfPi - 34'(rnd_shift(prod_q, 30));
    dtmp = 33'(rnd_shift(prod_q, 50 - AngleFracBits));
    trim = axis_q ? item_q.roll_trim : item_q.pitch_trim;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          state_d = ST_INC_P;
        end
      end
      ST_INC_P: begin
        mul_a = 38'(item_q.dx);  mul_b = RateK;
        state_d = ST_INC_R;
      end
      ST_INC_R: begin
        pe_d = sat36(40'(pe_q) + 40'(rnd_shift(prod_q, 40 - AngleFracBits)));
        mul_a = 38'(item_q.dy);  mul_b = RateK;
        state_d = ST_YAW;
      end
      ST_YAW: begin
        re_d = sat36(40'(re_q) + 40'(rnd_shift(prod_q, 40 - AngleFracBits)));
        mul_a = 38'(item_q.dz);  mul_b = YawK;
        state_d = ST_X;
      end
      ST_X: begin
        x_d = 26'(rnd_shift(prod_q, 12));
        state_d = ST_XX;
      end
      ST_XX: begin
        mul_a = 38'(x_q);  mul_b = 32'(x_q);
        state_d = ST_X2;
      end
      ST_X2: begin
        x2_d = 26'(rnd_shift(prod_q, 28));
        state_d = ST_D20;
      end
      ST_D20: begin
        // x2 / 20 by reciprocal; x2 is small enough for the floor to be exact.
        mul_a = 38'(x2_q);  mul_b = Div20K;
        state_d = ST_U;
      end
      ST_U: begin
        u_d = Q28One - 30'(prod_q >>> 28);
        state_d = ST_XU;
      end
      ST_XU: begin
        mul_a = 38'(x2_q);  mul_b = 32'(u_q);
        state_d = ST_V;
      end
      ST_V: begin
        v_d = 26'(rnd_shift(prod_q, 28));
        state_d = ST_D6;
      end
      ST_D6: begin
        mul_a = 38'(v_q);  mul_b = Div6K;
        state_d = ST_V6;
      end
      ST_V6: begin
        v_d = 26'(prod_q >>> 28);
        state_d = ST_XS;
      end
      ST_XS: begin
        mul_a = 38'(x_q);  mul_b = 32'(Q28One - 30'(v_q));
        state_d = ST_S;
      end
      ST_S: begin
        s_d = 27'(rnd_shift(prod_q, 28));
        state_d = ST_PS;
      end
      ST_PS: begin
        mul_a = 38'(re_q);  mul_b = 32'(s_q);
        state_d = ST_PSU;
      end
      ST_PSU: begin
        pe_d = sat36(40'(pe_q) + 40'(rnd_shift(prod_q, 28)));
        state_d = ST_RS;
      end
      ST_RS: begin
        mul_a = 38'(pe_q);  mul_b = 32'(s_q);
        state_d = ST_RSU;
      end
      ST_RSU: begin
        re_d = sat36(40'(re_q) - 40'(rnd_shift(prod_q, 28)));
        mul_a = 38'(item_q.ax);  mul_b = 32'(item_q.ax);
        state_d = ST_SQY;
      end
      ST_SQY: begin
        acc_d = 32'(prod_q);
        mul_a = 38'(item_q.ay);  mul_b = 32'(item_q.ay);
        state_d = ST_SQZ;
      end
      ST_SQZ: begin
        acc_d = acc_q + 32'(prod_q);
        mul_a = 38'(item_q.az);  mul_b = 32'(item_q.az);
        state_d = ST_SQS;
      end
      ST_SQS: begin
        acc_d = acc_q + 32'(prod_q);
        state_d = ST_MAG;
      end
      ST_MAG: begin
        root_start = 1'b1;
        state_d = ST_MAGW;
      end
      ST_MAGW: begin
        if (root_done) begin
          mag_d  = root_res[15:0];
          axis_d = 1'b0;
          state_d = ST_ANG;
        end
      end
      ST_ANG: begin
        qr_d  = '0;
        cnt_d = '0;
        rem_d = mabs;
        if (item_q.acc_zero) begin
          dang_d = '0;
          state_d = ST_TRIM;
        end else if (mabs >= {1'b0, mag_q}) begin
          // Ratio of one or more clamps to one.
          qr_d = Q30One;
          state_d = ST_ROOT;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem2 >= {2'b00, mag_q}) begin
          rem_d = 17'(rem2 - {2'b00, mag_q});
          qr_d  = {qr_q[29:0], 1'b1};
        end else begin
          rem_d = 17'(rem2);
          qr_d  = {qr_q[29:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DivSteps - 1)) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        root_start = 1'b1;
        root_rad = {1'b0, Q30One - qr_q, 30'd0};
        root_top = AsinTopBit;
        state_d = ST_ROOTW;
      end
      ST_ROOTW: begin
        root_rad = {1'b0, Q30One - qr_q, 30'd0};
        root_top = AsinTopBit;
        if (root_done) begin
          sq_d   = root_res;
          p_d    = asin_coef(3'd7);
          pidx_d = 3'd6;
          state_d = ST_PM;
        end
      end
      ST_PM: begin
        mul_a = 38'(p_q);  mul_b = $signed({1'b0, qr_q});
        state_d = ST_PA;
      end
      ST_PA: begin
        p_d = 32'(rnd_shift(prod_q, 30)) + asin_coef(pidx_q);
        pidx_d = pidx_q - 3'd1;
        state_d = (pidx_q == 3'd0) ? ST_SP : ST_PM;
      end
      ST_SP: begin
        mul_a = 38'({1'b0, sq_q});  mul_b = p_q;
        state_d = ST_R;
      end
      ST_R: begin
        r_d = rtmp[33] ? '0 : 32'(rtmp);
        state_d = ST_DEG;
      end
      ST_DEG: begin
        mul_a = 38'(r_q);  mul_b = DegK;
        state_d = ST_DEGU;
      end
      ST_DEGU: begin
        dang_d = comp[15] ? 33'(-dtmp) : dtmp;
        state_d = ST_TRIM;
      end
      ST_TRIM: begin
        if (axis_q) begin
          ra_d = sat36(40'(dang_q) - 40'(trim));
          state_d = ST_BLEND;
        end else begin
          pa_d = sat36(40'(dang_q) - 40'(trim));
          axis_d = 1'b1;
          state_d = ST_ANG;
        end
      end
      ST_BLEND: begin
        if (seeded_q) begin
          mul_a = 38'(pa_q) - 38'(pe_q);  mul_b = BlendK;
          state_d = ST_BP;
        end else begin
          pe_d = pa_q;
          re_d = ra_q;
          seeded_d = 1'b1;
          state_d = ST_LP;
        end
      end
      ST_BP: begin
        pe_d = sat36(40'(pe_q) + 40'(rnd_shift(prod_q, 30)));
        mul_a = 38'(ra_q) - 38'(re_q);  mul_b = BlendK;
        state_d = ST_BR;
      end
      ST_BR: begin
        re_d = sat36(40'(re_q) + 40'(rnd_shift(prod_q, 30)));
        state_d = ST_LP;
      end
      ST_LP: begin
        mul_a = 38'(pe_q) - 38'(plp_q);  mul_b = LpK;
        state_d = ST_LPP;
      end
      ST_LPP: begin
        plp_d = sat36(40'(plp_q) + 40'(rnd_shift(prod_q, 30)));
        mul_a = 38'(re_q) - 38'(rlp_q);  mul_b = LpK;
        state_d = ST_LPR;
      end
      ST_LPR: begin
        rlp_d = sat36(40'(rlp_q) + 40'(rnd_shift(prod_q, 30)));
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Hold here while the previous beat still sits unclaimed in the output register.
        if (!outv_q || !out_stall_i) begin
          outv_d = 1'b1;
          outp_d = plp_q;
          outr_d = rlp_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pe_q     <= '0;
      re_q     <= '0;
      plp_q    <= '0;
      rlp_q    <= '0;
      seeded_q <= 1'b0;
      outv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      pe_q     <= pe_d;
      re_q     <= re_d;
      plp_q    <= plp_d;
      rlp_q    <= rlp_d;
      seeded_q <= seeded_d;
      outv_q   <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pa_q   <= pa_d;
    ra_q   <= ra_d;
    outp_q <= outp_d;
    outr_q <= outr_d;
    axis_q <= axis_d;
    x_q    <= x_d;
    x2_q   <= x2_d;
    v_q    <= v_d;
    u_q    <= u_d;
    s_q    <= s_d;
    acc_q  <= acc_d;
    mag_q  <= mag_d;
    qr_q   <= qr_d;
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    p_q    <= p_d;
    r_q    <= r_d;
    pidx_q <= pidx_d;
    dang_q <= dang_d;
    prod_q <= mul_a * mul_b;
  end

  assign out_valid_o      = outv_q;
  assign pitch_smoothed_o = outp_q;
  assign roll_smoothed_o  = outr_q;

endmodule

### rtl/imu_complementary_attitude_core.sv
// Top level of the IMU pitch/roll complementary filter.
// Depends on ica_pkg, ica_front, ica_back and ica_root.
//
// Input channel: one beat carries an accelerometer and gyro sample triple
// (accel_*_i, rate_*_i) and is taken when in_valid_i is high and in_stall_o low.
// Output channel: one beat of pitch_smoothed_o and roll_smoothed_o (signed Q24
// degrees) per input beat, taken when out_valid_o is high and out_stall_i low.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (gyro offsets,
// angle trims); indexes above four are ignored. Write only while the block is idle.
// A two-beat queue in front holds further samples; the engine works each one through
// to the output register before it takes the next. The seeding sample skips the two
// blend multiplies. An axis whose ratio clamps to one skips the divider, and a zero
// accel vector skips the divider, arcsine root and polynomial on each axis. The work
// is set by the shared multiplier sequence, the bit-serial magnitude root run once per
// sample, and the bit-serial divider and arcsine root, each run once per axis.
// Reset clears the filter state, so the first sample after reset seeds the angles.
// When the receiver stalls, the result waits in the output register; the engine
// holds its next result until that register empties, and the queue then fills.
`timescale 1ns / 1ps
module imu_complementary_attitude_core import ica_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [35:0] pitch_smoothed_o,
  output logic signed [35:0] roll_smoothed_o
);

  logic      q_valid;
  logic      q_pop;
  ica_item_t q_item;

  ica_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .accel_x_i (accel_x_i),
    .accel_y_i (accel_y_i),
    .accel_z_i (accel_z_i),
    .rate_x_i  (rate_x_i),
    .rate_y_i  (rate_y_i),
    .rate_z_i  (rate_z_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  ica_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pitch_smoothed_o(pitch_smoothed_o),
    .roll_smoothed_o (roll_smoothed_o)
  );

endmodule
